/* hw/rtl/pbpc_pkg.sv */
// Shared constants, types and sequencer states of the polygon boundary point clamp.
`default_nettype none

package pbpc_pkg;

   // Polygon storage and coordinate format (signed Q15.8)
   localparam int MAX_VERTICES      = 16;
   localparam int COORD_WIDTH       = 24;
   localparam int VIDX_WIDTH        = 4;
   localparam int COUNT_WIDTH       = 5;
   localparam int MIN_POLY_VERTICES = 3;

   // Edge differences carry one extra bit, their products twice that
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;

   // Register port
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic [VIDX_WIDTH-1:0]         vidx_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]    csr_index_type;

   // Register indexes
   localparam csr_index_type CSR_VERTEX_COUNT = csr_index_type'(0);

   // Request codes
   localparam logic REQ_WRITE_VERTEX = 1'b0;
   localparam logic REQ_QUERY_POINT  = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_MUL_A,
      ST_MUL_B,
      ST_TALLY,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/pbpc_req_if.sv */
// Request channel: vertex writes and point queries.
`default_nettype none

interface pbpc_req_if import pbpc_pkg::*; ();

   logic      valid;
   logic      ready;
   logic      req_type;
   vidx_type  vertex_index;
   coord_type point_x;
   coord_type point_y;

   modport source (
      output valid, req_type, vertex_index, point_x, point_y,
      input  ready
   );

   modport sink (
      input  valid, req_type, vertex_index, point_x, point_y,
      output ready
   );

endinterface

`default_nettype wire

/* hw/rtl/pbpc_rsp_if.sv */
// Response channel: inside flag, status flags and resulting point.
`default_nettype none

interface pbpc_rsp_if import pbpc_pkg::*; ();

   logic      valid;
   logic      ready;
   logic      inside_res;
   logic      was_clamped;
   logic      too_few_vertices;
   coord_type result_x;
   coord_type result_y;

   modport source (
      output valid, inside_res, was_clamped, too_few_vertices, result_x, result_y,
      input  ready
   );

   modport sink (
      input  valid, inside_res, was_clamped, too_few_vertices, result_x, result_y,
      output ready
   );

endinterface

`default_nettype wire

/* hw/rtl/polygon_boundary_point_clamp.sv */
// Top level of the polygon boundary point clamp: vertex store, edge sequencer and clamp.
`default_nettype none

// Vertex writes are taken while idle and give no response. A point query walks the n
// vertices in use (vertex_count, capped at sixteen) one edge at a time: ST_DIFF forms
// the edge differences, then the single shared 25x25 multiplier forms the two cross
// products in ST_MUL_A and ST_MUL_B; with fewer than three vertices the query goes
// straight to ST_FINISH. The bounding box is gathered during the same sweep. One query
// is in flight at a time; the request channel is ready again once the response sits in
// the output register. Reading a vertex slot in use that was never written gives an
// undefined result.

module polygon_boundary_point_clamp import pbpc_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   pbpc_req_if.sink                       req_chan,
   pbpc_rsp_if.source                     rsp_chan,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   localparam count_type VERTEX_LIMIT = count_type'(MAX_VERTICES);
   localparam count_type MIN_COUNT    = count_type'(MIN_POLY_VERTICES);
   localparam count_type COUNT_ONE    = count_type'(1);
   localparam vidx_type  VIDX_ONE     = vidx_type'(1);

   // Control state
   state_type state_ff, state_in;
   count_type vertex_count_ff, vertex_count_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      cmp_pend_ff, cmp_pend_in;

   // Query datapath
   coord_type px_ff, px_in, py_ff, py_in;
   vidx_type  idx_ff, idx_in, last_idx_ff, last_idx_in;
   logic      few_ff, few_in, parity_ff, parity_in;
   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type min_x_ff, min_x_in, max_x_ff, max_x_in;
   coord_type min_y_ff, min_y_in, max_y_ff, max_y_in;
   diff_type  a_ff, a_in, dy_ff, dy_in, b_ff, b_in, c_ff, c_in;
   logic      straddle_ff, straddle_in;
   prod_type  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;

   // Response payload
   logic      inside_ff, inside_in, clamped_ff, clamped_in, too_few_ff, too_few_in;
   coord_type res_x_ff, res_x_in, res_y_ff, res_y_in;

   // Vertex store
   coord_type vtx_x_mem [MAX_VERTICES];
   coord_type vtx_y_mem [MAX_VERTICES];
   coord_type rd_x_ff, rd_y_ff;
   vidx_type  mem_raddr;
   logic      mem_we;

   // Shared multiplier and crossing test
   diff_type  mul_op_a, mul_op_b;
   prod_type  mul_p;
   logic      dy_pos, dy_neg, crossing;
   count_type count_eff;
   logic      out_free;
   logic      csr_write;
   csr_index_type csr_index;

   // Register port
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (csr_write && csr_index == CSR_VERTEX_COUNT) begin
         vertex_count_in = pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == CSR_VERTEX_COUNT) begin
         prdata = {{(CSR_DATA_WIDTH-COUNT_WIDTH){1'b0}}, vertex_count_ff};
      end
   end

   // Channel handshakes and response ports
   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.inside_res       = inside_ff;
   assign rsp_chan.was_clamped      = clamped_ff;
   assign rsp_chan.too_few_vertices = too_few_ff;
   assign rsp_chan.result_x         = res_x_ff;
   assign rsp_chan.result_y         = res_y_ff;
   assign out_free                  = !rsp_valid_ff || rsp_chan.ready;

   // Vertices in use, capped at the store depth
   assign count_eff = (vertex_count_ff > VERTEX_LIMIT) ? VERTEX_LIMIT : vertex_count_ff;

   // Shared multiplier: (px - xi) * dy first, then (xj - xi) * (py - yi)
   assign mul_op_a = (state_ff == ST_MUL_A) ? a_ff  : b_ff;
   assign mul_op_b = (state_ff == ST_MUL_A) ? dy_ff : c_ff;
   assign mul_p    = prod_type'(mul_op_a) * prod_type'(mul_op_b);

   // Crossing decision for the edge whose products just landed
   assign dy_neg   = dy_ff[DIFF_WIDTH-1];
   assign dy_pos   = !dy_ff[DIFF_WIDTH-1] && (dy_ff != '0);
   assign crossing = cmp_pend_ff && straddle_ff &&
                     ((dy_pos && (prod_a_ff < prod_b_ff)) ||
                      (dy_neg && (prod_a_ff > prod_b_ff)));

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in    = state_ff;
      mem_we      = 1'b0;
      mem_raddr   = idx_ff;
      cmp_pend_in = 1'b0;
      parity_in   = parity_ff ^ crossing;
      px_in       = px_ff;
      py_in       = py_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      few_in      = few_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      min_x_in    = min_x_ff;
      max_x_in    = max_x_ff;
      min_y_in    = min_y_ff;
      max_y_in    = max_y_ff;
      a_in        = a_ff;
      dy_in       = dy_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      straddle_in = straddle_ff;
      prod_a_in   = prod_a_ff;
      prod_b_in   = prod_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      inside_in   = inside_ff;
      clamped_in  = clamped_ff;
      too_few_in  = too_few_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.req_type == REQ_WRITE_VERTEX) begin
                  mem_we = 1'b1;
               end else begin
                  px_in     = req_chan.point_x;
                  py_in     = req_chan.point_y;
                  parity_in = 1'b0;
                  idx_in    = '0;
                  if (count_eff < MIN_COUNT) begin
                     few_in   = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     few_in      = 1'b0;
                     last_idx_in = vidx_type'(count_eff - COUNT_ONE);
                     mem_raddr   = vidx_type'(count_eff - COUNT_ONE);
                     state_in    = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            // closing vertex becomes the first edge's far end and seeds the box
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            min_x_in  = rd_x_ff;
            max_x_in  = rd_x_ff;
            min_y_in  = rd_y_ff;
            max_y_in  = rd_y_ff;
            mem_raddr = idx_ff;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            straddle_in = (rd_y_ff > py_ff) != (prev_y_ff > py_ff);
            a_in  = diff_type'(px_ff) - diff_type'(rd_x_ff);
            dy_in = diff_type'(prev_y_ff) - diff_type'(rd_y_ff);
            b_in  = diff_type'(prev_x_ff) - diff_type'(rd_x_ff);
            c_in  = diff_type'(py_ff) - diff_type'(rd_y_ff);
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            if (rd_x_ff < min_x_ff) min_x_in = rd_x_ff;
            if (rd_x_ff > max_x_ff) max_x_in = rd_x_ff;
            if (rd_y_ff < min_y_ff) min_y_in = rd_y_ff;
            if (rd_y_ff > max_y_ff) max_y_in = rd_y_ff;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            prod_a_in = mul_p;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            prod_b_in   = mul_p;
            cmp_pend_in = 1'b1;
            if (idx_ff == last_idx_ff) begin
               state_in = ST_TALLY;
            end else begin
               idx_in    = idx_ff + VIDX_ONE;
               mem_raddr = idx_ff + VIDX_ONE;
               state_in  = ST_DIFF;
            end
         end
         ST_TALLY: begin
            // last edge's crossing folds into the parity here
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               too_few_in   = few_ff;
               inside_in    = !few_ff && parity_ff;
               clamped_in   = !few_ff && !parity_ff;
               res_x_in     = px_ff;
               res_y_in     = py_ff;
               if (!few_ff && !parity_ff) begin
                  if (px_ff < min_x_ff)      res_x_in = min_x_ff;
                  else if (px_ff > max_x_ff) res_x_in = max_x_ff;
                  if (py_ff < min_y_ff)      res_y_in = min_y_ff;
                  else if (py_ff > max_y_ff) res_y_in = max_y_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         cmp_pend_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vertex_count_ff <= vertex_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         cmp_pend_ff     <= cmp_pend_in;
      end
   end

   // Datapath and payload registers
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      few_ff      <= few_in;
      parity_ff   <= parity_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      min_x_ff    <= min_x_in;
      max_x_ff    <= max_x_in;
      min_y_ff    <= min_y_in;
      max_y_ff    <= max_y_in;
      a_ff        <= a_in;
      dy_ff       <= dy_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      straddle_ff <= straddle_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      inside_ff   <= inside_in;
      clamped_ff  <= clamped_in;
      too_few_ff  <= too_few_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
   end

   // Vertex store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vtx_x_mem[req_chan.vertex_index] <= req_chan.point_x;
         vtx_y_mem[req_chan.vertex_index] <= req_chan.point_y;
      end
      rd_x_ff <= vtx_x_mem[mem_raddr];
      rd_y_ff <= vtx_y_mem[mem_raddr];
   end

endmodule

`default_nettype wire
